/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/som_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_pkg
// Request codes and fixed field widths of the shift-or matcher.
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int unsigned FuncW       = 2;
  localparam int unsigned SymbolW     = 8;
  localparam int unsigned PatPosW     = 6;
  localparam int unsigned CfgW        = 7;
  localparam int unsigned MatchStartW = 32;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_TEXT  = 2'd2,
    FUNC_START = 2'd3
  } func_e;

endpackage

/* rtl/shift_or_exact_matcher.sv */
// A text request goes from the symbol mask memory read register to the
// result register through the shift-or update; an output stall can hold it.
// Throughput: one request per cycle when not stalled; the mask memory is read
// or written at most once per request; the match vector update is a recurrence.
// Reset: all masks read as all ones (valid bits cleared), match vector all
// ones, text position zero, pattern length 1; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_or_exact_matcher
// Shift-Or (bitap) exact string matcher with a per-symbol mask memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shift_or_exact_matcher #(
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned PATTERN_BITS  = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [som_pkg::CfgW-1:0]            cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [som_pkg::FuncW-1:0]           func_i,
  input  logic [som_pkg::SymbolW-1:0]         symbol_i,
  input  logic [som_pkg::PatPosW-1:0]         pattern_pos_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                match_o,
  output logic [som_pkg::MatchStartW-1:0]     match_start_o
);

  localparam int unsigned AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned IW = $clog2(PATTERN_BITS);
  localparam logic [16:0]                 AlphaSize = 17'(ALPHABET_SIZE);
  localparam logic [som_pkg::CfgW-1:0]    PatLenMax = som_pkg::CfgW'(PATTERN_BITS);
  localparam logic [PATTERN_BITS-1:0]     OneBit    = PATTERN_BITS'(1);

  // --------------------------------------------------------------------------
  // Configuration: keep the sanitized match bit index (length - 1)
  // --------------------------------------------------------------------------
  logic [IW-1:0] mbit_q, mbit_d;

  always_comb begin
    mbit_d = mbit_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        mbit_d = '0;
      end else if (cfg_wdata_i > PatLenMax) begin
        mbit_d = IW'(PatLenMax - som_pkg::CfgW'(1));
      end else begin
        mbit_d = IW'(cfg_wdata_i - som_pkg::CfgW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbit_q <= '0;
    end else begin
      mbit_q <= mbit_d;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic                       s1_vld_q;
  som_pkg::func_e             s1_func_q;
  logic                       s1_mvld_q;
  logic                       s1_go;
  logic                       in_acc;
  logic                       out_vld_q;
  logic                       out_match_q;
  logic [som_pkg::MatchStartW-1:0] out_start_q;

  // a non-text request never needs the result slot
  assign s1_go      = (s1_func_q != som_pkg::FUNC_TEXT) || !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  som_pkg::func_e  in_func;
  logic            sym_ok;
  logic            pos_ok;
  logic [AW-1:0]   addr;
  logic [IW-1:0]   pos_idx;
  logic            ld_we;
  logic            rd_en;

  assign in_func = som_pkg::func_e'(func_i);
  assign sym_ok  = 17'(symbol_i) < AlphaSize;
  assign pos_ok  = som_pkg::CfgW'(pattern_pos_i) < PatLenMax;
  assign addr    = AW'(symbol_i);
  assign pos_idx = IW'(pattern_pos_i);
  assign ld_we   = in_acc && (in_func == som_pkg::FUNC_LOAD) && sym_ok && pos_ok;
  assign rd_en   = in_acc && (in_func == som_pkg::FUNC_TEXT);

  // --------------------------------------------------------------------------
  // Symbol mask memory; an entry without its valid bit reads as all ones
  // --------------------------------------------------------------------------
  logic [PATTERN_BITS-1:0]  mask_mem [ALPHABET_SIZE];
  logic [PATTERN_BITS-1:0]  rdata_q;
  logic [ALPHABET_SIZE-1:0] ent_vld_q;

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      if (ent_vld_q[addr]) begin
        mask_mem[addr][pos_idx] <= 1'b0;
      end else begin
        mask_mem[addr] <= ~(OneBit << pos_idx);
      end
    end
    if (rd_en) begin
      rdata_q <= mask_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      s1_mvld_q <= 1'b0;
    end else begin
      if (in_acc && (in_func == som_pkg::FUNC_CLEAR)) begin
        ent_vld_q <= '0;
      end else if (ld_we) begin
        ent_vld_q[addr] <= 1'b1;
      end
      if (rd_en) begin
        s1_mvld_q <= sym_ok && ent_vld_q[addr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: shift-or update of the match vector
  // --------------------------------------------------------------------------
  logic [PATTERN_BITS-1:0]  mvec_q, mvec_d;
  logic [POSITION_BITS-1:0] tpos_q, tpos_d;
  logic [PATTERN_BITS-1:0]  mask;
  logic [PATTERN_BITS-1:0]  mvec_nxt;
  logic                     hit;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     s1_fire;
  logic                     res_load;

  assign s1_fire   = s1_vld_q && s1_go;
  assign mask      = s1_mvld_q ? rdata_q : '1;
  assign mvec_nxt  = (mvec_q << 1) | mask;
  assign hit       = !mvec_nxt[mbit_q];
  assign start_pos = tpos_q - POSITION_BITS'(mbit_q);
  assign res_load  = s1_fire && (s1_func_q == som_pkg::FUNC_TEXT);

  always_comb begin
    mvec_d = mvec_q;
    tpos_d = tpos_q;
    if (s1_fire) begin
      case (s1_func_q)
        som_pkg::FUNC_CLEAR, som_pkg::FUNC_START: begin
          mvec_d = '1;
          tpos_d = '0;
        end
        som_pkg::FUNC_TEXT: begin
          mvec_d = mvec_nxt;
          tpos_d = tpos_q + POSITION_BITS'(1);
        end
        default: begin
          mvec_d = mvec_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_func_q <= som_pkg::FUNC_CLEAR;
      mvec_q    <= '1;
      tpos_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q  <= 1'b1;
        s1_func_q <= in_func;
      end else if (s1_go) begin
        s1_vld_q  <= 1'b0;
      end
      mvec_q <= mvec_d;
      tpos_q <= tpos_d;
      // hold the result while stalled
      if (res_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_match_q <= hit;
      out_start_q <= hit ? som_pkg::MatchStartW'(start_pos) : '0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign match_o       = out_match_q;
  assign match_start_o = out_start_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic clr_acc;
  logic restart_fire;

  assign clr_acc      = in_acc && (in_func == som_pkg::FUNC_CLEAR);
  assign restart_fire = s1_fire && ((s1_func_q == som_pkg::FUNC_CLEAR) ||
                                    (s1_func_q == som_pkg::FUNC_START));

  `ASSERT_CLK(a_clear_drops_masks, clr_acc |=> (ent_vld_q == '0))
  `ASSERT_CLK(a_restart_pos_zero, restart_fire |=> ((tpos_q == '0) && (mvec_q == '1)))
  `ASSERT_NEVER(a_nomatch_start, out_vld_q && !out_match_q && (out_start_q != '0))

endmodule
